### rtl/integer_matrix_multiply_defines.svh
// Assertion macros shared by the matrix multiply RTL.
// Depends on a clock named clock and a synchronous reset named reset in the
// module that includes it.
`ifndef INTEGER_MATRIX_MULTIPLY_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/imm_pkg.sv
// Package for the integer matrix multiply block: sizes, payload structs,
// sequencer step codes, control word format and the microcode table.
// No dependencies.
package imm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int ELEM_WIDTH = 16;
   localparam int IDX_WIDTH  = 3;
   localparam int DIM_WIDTH  = 4;
   localparam int ADDR_WIDTH = 2 * IDX_WIDTH;
   localparam int ACC_WIDTH  = 32;
   localparam int OPS_WIDTH  = 10;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int STEP_WIDTH = 3;

   // Input item codes
   typedef enum logic [1:0] {
      MODE_LOAD_A  = 2'd0,
      MODE_LOAD_B  = 2'd1,
      MODE_COMPUTE = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COLS_B    = 2'd2;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [IDX_WIDTH-1:0]         row_index;
      logic [IDX_WIDTH-1:0]         col_index;
      logic signed [ELEM_WIDTH-1:0] element_value;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_WIDTH-1:0]        out_row;
      logic [IDX_WIDTH-1:0]        out_col;
      logic signed [ACC_WIDTH-1:0] product_value;
      logic [OPS_WIDTH-1:0]        op_count;
      logic                        last;
   } rsp_payload_type;

   // Sequencer step addresses
   typedef logic [STEP_WIDTH-1:0] step_type;
   localparam step_type STEP_IDLE = 3'd0;
   localparam step_type STEP_READ = 3'd1;
   localparam step_type STEP_MUL  = 3'd2;
   localparam step_type STEP_ACC  = 3'd3;
   localparam step_type STEP_EMIT = 3'd4;
   localparam step_type STEP_NEXT = 3'd5;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_START    = 3'd1,
      COND_K_LAST   = 3'd2,
      COND_RSP_FREE = 3'd3,
      COND_RUN_LAST = 3'd4
   } cond_type;

   typedef struct packed {
      logic     take_req;
      logic     issue_rd;
      logic     do_mul;
      logic     do_acc;
      logic     do_emit;
      logic     do_next;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ctl_word_type;

   // Microcode: one control word per step
   function automatic ctl_word_type microcode(input step_type pc);
      ctl_word_type w;
      w = '{take_req: 1'b0, issue_rd: 1'b0, do_mul: 1'b0, do_acc: 1'b0,
            do_emit: 1'b0, do_next: 1'b0, cond: COND_ALWAYS,
            on_true: STEP_IDLE, on_false: STEP_IDLE};
      unique case (pc)
         STEP_IDLE: begin
            w.take_req = 1'b1;
            w.cond     = COND_START;
            w.on_true  = STEP_READ;
            w.on_false = STEP_IDLE;
         end
         STEP_READ: begin
            w.issue_rd = 1'b1;
            w.on_true  = STEP_MUL;
         end
         STEP_MUL: begin
            w.do_mul  = 1'b1;
            w.on_true = STEP_ACC;
         end
         STEP_ACC: begin
            w.do_acc   = 1'b1;
            w.cond     = COND_K_LAST;
            w.on_true  = STEP_EMIT;
            w.on_false = STEP_READ;
         end
         STEP_EMIT: begin
            w.do_emit  = 1'b1;
            w.cond     = COND_RSP_FREE;
            w.on_true  = STEP_NEXT;
            w.on_false = STEP_EMIT;
         end
         STEP_NEXT: begin
            w.do_next  = 1'b1;
            w.cond     = COND_RUN_LAST;
            w.on_true  = STEP_IDLE;
            w.on_false = STEP_READ;
         end
         default: begin
            w.on_true = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // Map a dimension register to its usable range
   function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] d);
      logic [DIM_WIDTH-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_WIDTH'(1);
      end else if (d > DIM_WIDTH'(MAX_DIM)) begin
         r = DIM_WIDTH'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

### rtl/integer_matrix_multiply.sv
// Integer matrix multiply: A and B element stores, a microcoded sequencer
// and a single multiply-accumulate datapath. Depends on imm_pkg and on
// integer_matrix_multiply_defines.svh for its assertions.
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_stall     req_data  (req_payload_type)
//   rsp      out        rsp_valid / rsp_stall     rsp_data  (rsp_payload_type)
//   csr      in         csr_write                 csr_index, csr_data
//
// A load item is written into its store and leaves the sequencer idle. A
// compute item holds the input side until the run ends: each
// multiply-accumulate walks read, multiply and accumulate steps on the one
// read port per store and the one multiplier. Reset sets the sequencer idle
// and each dimension to 8; the stores are not cleared. A stall on rsp holds
// the sequencer in its emit step until the output register frees.
module integer_matrix_multiply import imm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_data,
   input  logic                       csr_write,
   input  logic [CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [DIM_WIDTH-1:0]       csr_data
);

   logic [DIM_WIDTH-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_WIDTH-1:0] nr, nk, nc;
   step_type             pc_ff, pc_in;
   ctl_word_type         ctl;
   logic                 cond_hit;
   logic                 req_xfer, start, load_a, load_b;
   logic [IDX_WIDTH-1:0] i_ff, j_ff, k_ff;
   logic                 k_last, j_last, run_last;
   logic signed [ELEM_WIDTH-1:0] mem_a [MAX_DIM*MAX_DIM];
   logic signed [ELEM_WIDTH-1:0] mem_b [MAX_DIM*MAX_DIM];
   logic signed [ELEM_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic signed [ACC_WIDTH-1:0]  prod_in, prod_ff, acc_ff;
   logic [OPS_WIDTH-1:0]         total_in, total_ff;
   logic                         rsp_free, emit_load;
   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_WIDTH'(MAX_DIM);
         inner_dim_ff <= DIM_WIDTH'(MAX_DIM);
         cols_b_ff    <= DIM_WIDTH'(MAX_DIM);
      end else if (csr_write) begin
         if (csr_index == CSR_ROWS_A)    rows_a_ff    <= csr_data;
         if (csr_index == CSR_INNER_DIM) inner_dim_ff <= csr_data;
         if (csr_index == CSR_COLS_B)    cols_b_ff    <= csr_data;
      end
   end

   assign nr = clamp_dim(rows_a_ff);
   assign nk = clamp_dim(inner_dim_ff);
   assign nc = clamp_dim(cols_b_ff);

   // Control word and item decode
   assign ctl       = microcode(pc_ff);
   assign req_stall = !ctl.take_req;
   assign req_xfer  = req_valid && !req_stall;
   assign start     = req_xfer && (req_data.mode == MODE_COMPUTE);
   assign load_a    = req_xfer && (req_data.mode == MODE_LOAD_A);
   assign load_b    = req_xfer && (req_data.mode == MODE_LOAD_B);

   assign k_last   = ({1'b0, k_ff} == nk - DIM_WIDTH'(1));
   assign j_last   = ({1'b0, j_ff} == nc - DIM_WIDTH'(1));
   assign run_last = j_last && ({1'b0, i_ff} == nr - DIM_WIDTH'(1));

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_load = ctl.do_emit && rsp_free;

   // Evaluate the jump condition
   always_comb begin
      unique case (ctl.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_START:    cond_hit = start;
         COND_K_LAST:   cond_hit = k_last;
         COND_RSP_FREE: cond_hit = rsp_free;
         COND_RUN_LAST: cond_hit = run_last;
         default:       cond_hit = 1'b1;
      endcase
      pc_in = cond_hit ? ctl.on_true : ctl.on_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Element stores: write on load transfer, registered read
   always_ff @(posedge clock) begin
      if (load_a) mem_a[{req_data.row_index, req_data.col_index}] <= req_data.element_value;
      if (load_b) mem_b[{req_data.row_index, req_data.col_index}] <= req_data.element_value;
      if (ctl.issue_rd) begin
         a_rd_ff <= mem_a[{i_ff, k_ff}];
         b_rd_ff <= mem_b[{k_ff, j_ff}];
      end
   end

   // Loop counters and multiply-accumulate datapath
   assign prod_in  = ACC_WIDTH'(a_rd_ff) * ACC_WIDTH'(b_rd_ff);
   assign total_in = OPS_WIDTH'(nr) * OPS_WIDTH'(nk) * OPS_WIDTH'(nc);

   always_ff @(posedge clock) begin
      if (start) begin
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         acc_ff   <= '0;
         total_ff <= total_in;
      end
      if (ctl.do_mul) prod_ff <= prod_in;
      if (ctl.do_acc) begin
         acc_ff <= acc_ff + prod_ff;
         if (!k_last) k_ff <= k_ff + IDX_WIDTH'(1);
      end
      if (ctl.do_next) begin
         k_ff   <= '0;
         acc_ff <= '0;
         if (j_last) begin
            j_ff <= '0;
            i_ff <= i_ff + IDX_WIDTH'(1);
         end else begin
            j_ff <= j_ff + IDX_WIDTH'(1);
         end
      end
   end

   // Output register: load on emit, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_data_ff.out_row       <= i_ff;
         rsp_data_ff.out_col       <= j_ff;
         rsp_data_ff.product_value <= acc_ff;
         rsp_data_ff.op_count      <= run_last ? total_ff : '0;
         rsp_data_ff.last          <= run_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "integer_matrix_multiply_defines.svh"

   `IMM_ASSERT_NEXT(a_last_to_idle, (pc_ff == STEP_NEXT) && run_last, pc_ff == STEP_IDLE, "run did not end after last element")
   `IMM_ASSERT_NOW(a_k_in_range, (pc_ff != STEP_IDLE), {1'b0, k_ff} < nk, "inner index beyond inner_dim")
   `IMM_ASSERT_NEXT(a_emit_loads, (pc_ff == STEP_EMIT) && rsp_free, rsp_valid_ff, "emit step left output empty")
   `IMM_ASSERT_NOW(a_no_take_busy, req_xfer, pc_ff == STEP_IDLE, "item taken while sequencer busy")

endmodule
